// ===== sv/mlpq_pkg.sv =====
// Shared types and constants for the multi-level priority FIFO core.
// Holds the request/response transaction structs and status codes.
// No dependencies.
package mlpq_pkg;

  localparam int LEVELS_DEF = 5;
  localparam int DEPTH_DEF  = 16;

  localparam int DATA_W   = 32;
  localparam int LEVEL_W  = 3;
  localparam int STATUS_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] data_in;
    logic [LEVEL_W-1:0]       level;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_out;
  } rsp_t;

endpackage

// ===== sv/mlpq_store.sv =====
// Entry storage for all priority levels: one write port, one read port,
// registered read data. Uses mlpq_pkg for the data width.
module mlpq_store #(
  parameter int ADDR_W = 7
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic signed [mlpq_pkg::DATA_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic signed [mlpq_pkg::DATA_W-1:0] rd_data
);

  logic signed [mlpq_pkg::DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/multi_level_priority_fifo_core.sv =====
// Strict-priority multi-queue: one FIFO per level, level 1 most urgent.
// The response strobe (done) comes in the cycle after start is taken.
// Throughput: one transaction per cycle while busy is low; remove data comes
// through the entry memory's registered read port.
// Reset: rst (synchronous) empties every level; busy is high the cycle after.
// Entry memory is not cleared; the receiver cannot stall the response.
module multi_level_priority_fifo_core #(
  parameter int LEVELS = mlpq_pkg::LEVELS_DEF,
  parameter int DEPTH  = mlpq_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mlpq_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output mlpq_pkg::rsp_t response
);

  localparam int QW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = QW + PTR_W;

  logic [PTR_W-1:0] rptr [LEVELS];
  logic [PTR_W-1:0] wptr [LEVELS];
  logic [CNT_W-1:0] cnt  [LEVELS];

  logic                               accept;
  logic                               is_insert;
  logic                               level_ok;
  logic [QW-1:0]                      q_ins;
  logic                               ins_full;
  logic                               ins_ok;
  logic                               found;
  logic [QW-1:0]                      q_rem;
  logic                               rem_ok;
  logic [mlpq_pkg::STATUS_W-1:0]      status_next;
  logic [mlpq_pkg::STATUS_W-1:0]      status;
  logic                               take_mem;
  logic signed [mlpq_pkg::DATA_W-1:0] rd_data;

  assign accept    = start && !busy && !rst;
  assign is_insert = (request.operation == mlpq_pkg::OP_INSERT);
  assign level_ok  = (request.level != '0) &&
                     (request.level <= mlpq_pkg::LEVEL_W'(LEVELS));
  assign q_ins     = QW'(request.level - 3'd1);

  always_comb begin
    ins_full = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (q_ins == QW'(i) && cnt[i] == CNT_W'(DEPTH)) begin
        ins_full = 1'b1;
      end
    end
  end

  // Lowest-numbered non-empty level wins: scan from the back, keep the last hit.
  always_comb begin
    found = 1'b0;
    q_rem = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cnt[i] != '0) begin
        found = 1'b1;
        q_rem = QW'(i);
      end
    end
  end

  assign ins_ok = accept && is_insert && level_ok && !ins_full;
  assign rem_ok = accept && !is_insert && found;

  always_comb begin
    if (is_insert) begin
      if (!level_ok) begin
        status_next = mlpq_pkg::ST_INVALID;
      end else if (ins_full) begin
        status_next = mlpq_pkg::ST_FULL;
      end else begin
        status_next = mlpq_pkg::ST_INSERTED;
      end
    end else if (found) begin
      status_next = mlpq_pkg::ST_REMOVED;
    end else begin
      status_next = mlpq_pkg::ST_UNDERFLOW;
    end
  end

  mlpq_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ins_ok),
    .wr_addr ({q_ins, wptr[q_ins]}),
    .wr_data (request.data_in),
    .rd_en   (rem_ok),
    .rd_addr ({q_rem, rptr[q_rem]}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        rptr[i] <= '0;
        wptr[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        if (ins_ok && q_ins == QW'(i)) begin
          wptr[i] <= (wptr[i] == PTR_W'(DEPTH - 1)) ? '0 : wptr[i] + 1'b1;
          cnt[i]  <= cnt[i] + 1'b1;
        end
        if (rem_ok && q_rem == QW'(i)) begin
          rptr[i] <= (rptr[i] == PTR_W'(DEPTH - 1)) ? '0 : rptr[i] + 1'b1;
          cnt[i]  <= cnt[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      take_mem <= 1'b0;
    end else begin
      busy     <= 1'b0;
      done     <= accept;
      take_mem <= rem_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  assign response.status   = status;
  assign response.data_out = take_mem ? rd_data : '0;

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done == $past(accept))
    else $error("response strobe does not follow accepted transaction");

  a_removed_reads_mem: assert property (@(posedge clk) disable iff (rst)
    done && response.status == mlpq_pkg::ST_REMOVED |-> take_mem)
    else $error("removed status without a memory read");

  a_zero_data_unless_removed: assert property (@(posedge clk) disable iff (rst)
    done && response.status != mlpq_pkg::ST_REMOVED |-> response.data_out == '0)
    else $error("data_out not zero on a non-remove response");

  a_remove_returns_data: assert property (@(posedge clk) disable iff (rst)
    rem_ok |=> done && take_mem)
    else $error("accepted remove not followed by a data response");

endmodule
